### hdl/rpn_pkg.sv
// rpn_pkg: shared types and constants of the reverse Polish calculator
// no dependencies; every other file of the block refers to it by scoped names

package rpn_pkg;

    localparam int W_OP   = 4;
    localparam int W_VAL  = 32;
    localparam int W_ERR  = 3;
    localparam int W_SP   = 8;
    localparam int FRAC   = 16;
    localparam int DIV_W  = W_VAL + FRAC;
    localparam int CNT_W  = $clog2(DIV_W);

    localparam logic [W_VAL-1:0] VAL_MAX = {1'b0, {(W_VAL-1){1'b1}}};
    localparam logic [W_VAL-1:0] VAL_MIN = {1'b1, {(W_VAL-1){1'b0}}};

    localparam logic [W_OP-1:0] OP_PUSH  = 4'd0;
    localparam logic [W_OP-1:0] OP_ADD   = 4'd1;
    localparam logic [W_OP-1:0] OP_SUB   = 4'd2;
    localparam logic [W_OP-1:0] OP_MUL   = 4'd3;
    localparam logic [W_OP-1:0] OP_DIV   = 4'd4;
    localparam logic [W_OP-1:0] OP_MOD   = 4'd5;
    localparam logic [W_OP-1:0] OP_CLEAR = 4'd6;
    localparam logic [W_OP-1:0] OP_PEEK  = 4'd7;
    localparam logic [W_OP-1:0] OP_SWAP  = 4'd8;
    localparam logic [W_OP-1:0] OP_POP   = 4'd9;

    typedef enum logic [3:0] {
        K_PUSH, K_ADD, K_SUB, K_MUL, K_DIV, K_MOD,
        K_CLEAR, K_PEEK, K_SWAP, K_POP, K_NOP
    } t_kind;

    typedef enum logic [W_ERR-1:0] {
        ERR_OK       = 3'd0,
        ERR_EMPTY    = 3'd1,
        ERR_FULL     = 3'd2,
        ERR_ZERO_DIV = 3'd3,
        ERR_SHORT    = 3'd4
    } t_err;

    typedef enum logic [2:0] {
        B_IDLE, B_GOT_B, B_GOT_A, B_SWAP, B_MUL, B_DIV, B_OUT
    } t_bstate;

    typedef struct packed {
        t_kind                    kind;
        logic signed [W_VAL-1:0]  value;
    } t_cmd;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  num;
        logic [W_VAL-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quo;
        logic [W_VAL-1:0]  rem;
    } t_div_rsp;

endpackage

### hdl/rpn_ifs.sv
// rpn_ifs: valid/ready channel interfaces for token words and result words
// depends on rpn_pkg for field widths

interface rpn_tok_if;
    logic                             valid;
    logic                             ready;
    logic [rpn_pkg::W_OP-1:0]         operation;
    logic signed [rpn_pkg::W_VAL-1:0] operand_value;

    modport source (output valid, operation, operand_value, input ready);
    modport sink   (input valid, operation, operand_value, output ready);
endinterface

interface rpn_res_if;
    logic                             valid;
    logic                             ready;
    logic signed [rpn_pkg::W_VAL-1:0] top_value;
    logic signed [rpn_pkg::W_VAL-1:0] second_value;
    logic                             value_valid;
    logic [rpn_pkg::W_ERR-1:0]        error_code;

    modport source (output valid, top_value, second_value, value_valid, error_code,
                    input ready);
    modport sink   (input valid, top_value, second_value, value_valid, error_code,
                    output ready);
endinterface

### hdl/rpn_stack_calculator.sv
// rpn_stack_calculator: top level of the reverse Polish Q16.16 calculator
// depends on rpn_pkg, rpn_ifs, rpn_front, rpn_cmd_fifo and rpn_back
//
//  channel   dir  payload                                          handshake
//  i_tok     in   operation[3:0], operand_value[31:0]              valid/ready
//  o_res     out  top_value, second_value, value_valid, error_code valid/ready
//
//  push, clear and unused codes go straight to the output word; pop reads one stack word;
//  add, sub, peek read two; mul and swap add a product or write-back state; div and mod wait
//  on the 48-step radix-2 divider; tokens pass the two-word command queue ahead of the back end
//  synchronous active-low reset empties the stack, the queue and the output word
//  a stalled output holds the back end only when it has its next word ready

module rpn_stack_calculator #(
    parameter int STACK_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rpn_tok_if.sink     i_tok,
    rpn_res_if.source   o_res
);

    logic           w_push;
    logic           w_full;
    logic           w_pop;
    logic           w_cmd_valid;
    rpn_pkg::t_cmd  w_front_cmd;
    rpn_pkg::t_cmd  w_head_cmd;

    rpn_front u_front (
        .i_tok  (i_tok),
        .i_full (w_full),
        .o_push (w_push),
        .o_cmd  (w_front_cmd)
    );

    rpn_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_cmd_valid),
        .o_data  (w_head_cmd)
    );

    rpn_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_head_cmd),
        .o_cmd_pop   (w_pop),
        .o_res       (o_res)
    );

endmodule

### hdl/rpn_front.sv
// rpn_front: takes token words and classifies the operation code
// depends on rpn_pkg and rpn_tok_if; feeds the command queue

module rpn_front (
    rpn_tok_if.sink         i_tok,
    input  logic            i_full,
    output logic            o_push,
    output rpn_pkg::t_cmd   o_cmd
);

    rpn_pkg::t_kind w_kind;

    always_comb begin
        unique case (i_tok.operation)
            rpn_pkg::OP_PUSH:  w_kind = rpn_pkg::K_PUSH;
            rpn_pkg::OP_ADD:   w_kind = rpn_pkg::K_ADD;
            rpn_pkg::OP_SUB:   w_kind = rpn_pkg::K_SUB;
            rpn_pkg::OP_MUL:   w_kind = rpn_pkg::K_MUL;
            rpn_pkg::OP_DIV:   w_kind = rpn_pkg::K_DIV;
            rpn_pkg::OP_MOD:   w_kind = rpn_pkg::K_MOD;
            rpn_pkg::OP_CLEAR: w_kind = rpn_pkg::K_CLEAR;
            rpn_pkg::OP_PEEK:  w_kind = rpn_pkg::K_PEEK;
            rpn_pkg::OP_SWAP:  w_kind = rpn_pkg::K_SWAP;
            rpn_pkg::OP_POP:   w_kind = rpn_pkg::K_POP;
            default:           w_kind = rpn_pkg::K_NOP;
        endcase
    end

    assign i_tok.ready = !i_full;
    assign o_push      = i_tok.valid && !i_full;
    assign o_cmd.kind  = w_kind;
    assign o_cmd.value = i_tok.operand_value;

endmodule

### hdl/rpn_cmd_fifo.sv
// rpn_cmd_fifo: two-entry queue of classified commands between front and back
// depends on rpn_pkg for the command type

module rpn_cmd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rpn_pkg::t_cmd   i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output rpn_pkg::t_cmd   o_data
);

    rpn_pkg::t_cmd r_data [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    logic [1:0]    n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_data;
        end
    end

    assign o_full  = r_count[1];
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_data[r_rd_ptr];

endmodule

### hdl/rpn_div.sv
// rpn_div: radix-2 restoring unsigned divider, one quotient bit per cycle
// depends on rpn_pkg; shared by divide and integer modulo in rpn_back

module rpn_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rpn_pkg::t_div_req i_req,
    output rpn_pkg::t_div_rsp o_rsp
);

    logic                           r_busy;
    logic                           r_done;
    logic [rpn_pkg::CNT_W-1:0]      r_cnt;
    logic [rpn_pkg::DIV_W-1:0]      r_num;
    logic [rpn_pkg::W_VAL-1:0]      r_rem;
    logic [rpn_pkg::W_VAL-1:0]      r_den;
    logic [rpn_pkg::W_VAL:0]        w_shift;
    logic [rpn_pkg::W_VAL:0]        w_diff;
    logic                           w_ge;
    logic [rpn_pkg::W_VAL-1:0]      n_rem;

    always_comb begin
        w_shift = {r_rem, r_num[rpn_pkg::DIV_W-1]};
        w_diff  = w_shift - {1'b0, r_den};
        w_ge    = (w_shift >= {1'b0, r_den});
        n_rem   = w_ge ? w_diff[rpn_pkg::W_VAL-1:0] : w_shift[rpn_pkg::W_VAL-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + rpn_pkg::CNT_W'(1);
                if (r_cnt == rpn_pkg::CNT_W'(rpn_pkg::DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[rpn_pkg::DIV_W-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_num;
    assign o_rsp.rem  = r_rem;

endmodule

### hdl/rpn_back.sv
// rpn_back: executes commands on the value stack and registers the result word
// depends on rpn_pkg, rpn_res_if and rpn_div

module rpn_back #(
    parameter int STACK_DEPTH = 128
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  rpn_pkg::t_cmd   i_cmd,
    output logic            o_cmd_pop,
    rpn_res_if.source       o_res
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam logic [rpn_pkg::W_SP-1:0] DEPTH_W = rpn_pkg::W_SP'(STACK_DEPTH);
    localparam int VW = rpn_pkg::W_VAL;
    localparam int FR = rpn_pkg::FRAC;

    logic [VW-1:0] r_mem [STACK_DEPTH];

    rpn_pkg::t_bstate           r_state, n_state;
    logic [rpn_pkg::W_SP-1:0]   r_sp, n_sp;
    rpn_pkg::t_kind             r_kind, n_kind;
    logic signed [VW-1:0]       r_b, n_b;
    logic                       r_empty, n_empty;
    logic                       r_miss, n_miss;
    logic                       r_neg, n_neg;
    logic signed [2*VW-1:0]     r_prod, n_prod;
    rpn_pkg::t_err              r_err, n_err;
    logic signed [VW-1:0]       r_top, n_top;
    logic signed [VW-1:0]       r_sec, n_sec;
    logic                       r_vld, n_vld;
    logic signed [VW-1:0]       r_rdata;

    logic                       r_o_valid;
    logic signed [VW-1:0]       r_o_top;
    logic signed [VW-1:0]       r_o_sec;
    logic                       r_o_vld;
    rpn_pkg::t_err              r_o_err;

    logic                       w_re, w_we, w_load_out, w_out_free;
    logic [AW-1:0]              w_raddr, w_waddr;
    logic [VW-1:0]              w_wdata;
    logic [rpn_pkg::W_SP-1:0]   w_sp_m1, w_sp_m2, w_sp_p1;
    logic signed [VW-1:0]       w_aval, w_bval;
    logic [VW-1:0]              w_amag, w_bmag, w_rbmag;
    logic [VW:0]                w_sum, w_dif;
    logic [rpn_pkg::DIV_W-1:0]  w_mq;
    logic [VW-1:0]              w_mulres, w_divres, w_modres;
    rpn_pkg::t_err              w_arith_err;

    rpn_pkg::t_div_req          w_div_req;
    rpn_pkg::t_div_rsp          w_div_rsp;

    function automatic logic [VW-1:0] f_abs(input logic [VW-1:0] v);
        return v[VW-1] ? (~v + VW'(1)) : v;
    endfunction

    function automatic logic [VW-1:0] f_sat33(input logic [VW:0] v);
        logic [VW-1:0] res;
        if (v[VW] != v[VW-1]) begin
            res = v[VW] ? rpn_pkg::VAL_MIN : rpn_pkg::VAL_MAX;
        end else begin
            res = v[VW-1:0];
        end
        return res;
    endfunction

    function automatic logic [VW-1:0] f_sat48(input logic [rpn_pkg::DIV_W-1:0] v);
        logic [VW-1:0] res;
        if ((&v[rpn_pkg::DIV_W-1:VW-1]) || !(|v[rpn_pkg::DIV_W-1:VW-1])) begin
            res = v[VW-1:0];
        end else begin
            res = v[rpn_pkg::DIV_W-1] ? rpn_pkg::VAL_MIN : rpn_pkg::VAL_MAX;
        end
        return res;
    endfunction

    rpn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // datapath helpers
    always_comb begin
        w_sp_m1 = r_sp - rpn_pkg::W_SP'(1);
        w_sp_m2 = r_sp - rpn_pkg::W_SP'(2);
        w_sp_p1 = r_sp + rpn_pkg::W_SP'(1);
        w_bval  = r_miss ? VW'(0) : r_rdata;
        w_aval  = r_miss ? VW'(0) : r_rdata;
        w_amag  = f_abs(w_aval);
        w_bmag  = f_abs(w_bval);
        w_rbmag = f_abs(r_b);
        w_sum   = {w_aval[VW-1], w_aval} + {r_b[VW-1], r_b};
        w_dif   = {w_aval[VW-1], w_aval} - {r_b[VW-1], r_b};
        w_mq    = r_prod[2*VW-1:FR];
        if (r_prod[2*VW-1] && (|r_prod[FR-1:0])) begin
            w_mq = w_mq + rpn_pkg::DIV_W'(1);
        end
        w_mulres = f_sat48(w_mq);
        if (!r_neg) begin
            w_divres = (|w_div_rsp.quo[rpn_pkg::DIV_W-1:VW-1]) ? rpn_pkg::VAL_MAX
                                                                : w_div_rsp.quo[VW-1:0];
        end else if ((|w_div_rsp.quo[rpn_pkg::DIV_W-1:VW])
                     || (w_div_rsp.quo[VW-1] && (|w_div_rsp.quo[VW-2:0]))) begin
            w_divres = rpn_pkg::VAL_MIN;
        end else begin
            w_divres = ~w_div_rsp.quo[VW-1:0] + VW'(1);
        end
        w_modres = {w_div_rsp.rem[FR-1:0], {FR{1'b0}}};
        if (r_neg) begin
            w_modres = ~w_modres + VW'(1);
        end
        w_arith_err = r_empty ? rpn_pkg::ERR_EMPTY : rpn_pkg::ERR_OK;
        w_out_free  = !r_o_valid || o_res.ready;
    end

    always_comb begin
        n_state   = r_state;
        n_sp      = r_sp;
        n_kind    = r_kind;
        n_b       = r_b;
        n_empty   = r_empty;
        n_miss    = r_miss;
        n_neg     = r_neg;
        n_prod    = r_prod;
        n_err     = r_err;
        n_top     = r_top;
        n_sec     = r_sec;
        n_vld     = r_vld;
        w_re      = 1'b0;
        w_raddr   = '0;
        w_we      = 1'b0;
        w_waddr   = '0;
        w_wdata   = '0;
        o_cmd_pop = 1'b0;
        w_load_out = 1'b0;
        w_div_req = '0;

        unique case (r_state)
            rpn_pkg::B_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_kind    = i_cmd.kind;
                    n_err     = rpn_pkg::ERR_OK;
                    n_top     = '0;
                    n_sec     = '0;
                    n_vld     = 1'b0;
                    n_empty   = 1'b0;
                    n_miss    = 1'b0;
                    n_state   = rpn_pkg::B_OUT;
                    unique case (i_cmd.kind)
                        rpn_pkg::K_PUSH: begin
                            if (r_sp < DEPTH_W) begin
                                w_we    = 1'b1;
                                w_waddr = r_sp[AW-1:0];
                                w_wdata = i_cmd.value;
                                n_sp    = w_sp_p1;
                            end else begin
                                n_err = rpn_pkg::ERR_FULL;
                            end
                        end
                        rpn_pkg::K_CLEAR: begin
                            n_sp = '0;
                        end
                        rpn_pkg::K_PEEK, rpn_pkg::K_SWAP: begin
                            if (r_sp < rpn_pkg::W_SP'(2)) begin
                                n_err = rpn_pkg::ERR_SHORT;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = w_sp_m1[AW-1:0];
                                n_state = rpn_pkg::B_GOT_B;
                            end
                        end
                        rpn_pkg::K_ADD, rpn_pkg::K_SUB, rpn_pkg::K_MUL,
                        rpn_pkg::K_DIV, rpn_pkg::K_MOD, rpn_pkg::K_POP: begin
                            if (r_sp != '0) begin
                                w_re    = 1'b1;
                                w_raddr = w_sp_m1[AW-1:0];
                                n_sp    = w_sp_m1;
                            end else begin
                                n_miss  = 1'b1;
                                n_empty = 1'b1;
                            end
                            n_state = rpn_pkg::B_GOT_B;
                        end
                        default: ;
                    endcase
                end
            end

            rpn_pkg::B_GOT_B: begin
                n_b    = w_bval;
                n_miss = 1'b0;
                unique case (r_kind)
                    rpn_pkg::K_POP: begin
                        n_top   = w_bval;
                        n_vld   = !r_empty;
                        n_err   = w_arith_err;
                        n_state = rpn_pkg::B_OUT;
                    end
                    rpn_pkg::K_PEEK, rpn_pkg::K_SWAP: begin
                        w_re    = 1'b1;
                        w_raddr = w_sp_m2[AW-1:0];
                        n_state = rpn_pkg::B_GOT_A;
                    end
                    default: begin
                        if ((r_kind == rpn_pkg::K_DIV && w_bval == '0)
                            || (r_kind == rpn_pkg::K_MOD && w_bmag[VW-1:FR] == '0)) begin
                            n_err   = r_empty ? rpn_pkg::ERR_EMPTY : rpn_pkg::ERR_ZERO_DIV;
                            n_state = rpn_pkg::B_OUT;
                        end else begin
                            if (r_sp != '0) begin
                                w_re    = 1'b1;
                                w_raddr = w_sp_m1[AW-1:0];
                                n_sp    = w_sp_m1;
                            end else begin
                                n_miss  = 1'b1;
                                n_empty = 1'b1;
                            end
                            n_state = rpn_pkg::B_GOT_A;
                        end
                    end
                endcase
            end

            rpn_pkg::B_GOT_A: begin
                n_err = w_arith_err;
                unique case (r_kind)
                    rpn_pkg::K_PEEK: begin
                        n_top   = r_b;
                        n_sec   = r_rdata;
                        n_vld   = 1'b1;
                        n_state = rpn_pkg::B_OUT;
                    end
                    rpn_pkg::K_SWAP: begin
                        w_we    = 1'b1;
                        w_waddr = w_sp_m1[AW-1:0];
                        w_wdata = r_rdata;
                        n_state = rpn_pkg::B_SWAP;
                    end
                    rpn_pkg::K_ADD, rpn_pkg::K_SUB: begin
                        w_we    = 1'b1;
                        w_waddr = r_sp[AW-1:0];
                        w_wdata = (r_kind == rpn_pkg::K_ADD) ? f_sat33(w_sum) : f_sat33(w_dif);
                        n_sp    = w_sp_p1;
                        n_state = rpn_pkg::B_OUT;
                    end
                    rpn_pkg::K_MUL: begin
                        n_prod  = w_aval * r_b;
                        n_state = rpn_pkg::B_MUL;
                    end
                    rpn_pkg::K_DIV: begin
                        w_div_req.start = 1'b1;
                        w_div_req.num   = {w_amag, {FR{1'b0}}};
                        w_div_req.den   = w_rbmag;
                        n_neg           = w_aval[VW-1] ^ r_b[VW-1];
                        n_state         = rpn_pkg::B_DIV;
                    end
                    rpn_pkg::K_MOD: begin
                        w_div_req.start = 1'b1;
                        w_div_req.num   = {{VW{1'b0}}, w_amag[VW-1:FR]};
                        w_div_req.den   = {{FR{1'b0}}, w_rbmag[VW-1:FR]};
                        n_neg           = w_aval[VW-1];
                        n_state         = rpn_pkg::B_DIV;
                    end
                    default: begin
                        n_state = rpn_pkg::B_OUT;
                    end
                endcase
            end

            rpn_pkg::B_SWAP: begin
                w_we    = 1'b1;
                w_waddr = w_sp_m2[AW-1:0];
                w_wdata = r_b;
                n_state = rpn_pkg::B_OUT;
            end

            rpn_pkg::B_MUL: begin
                w_we    = 1'b1;
                w_waddr = r_sp[AW-1:0];
                w_wdata = w_mulres;
                n_sp    = w_sp_p1;
                n_state = rpn_pkg::B_OUT;
            end

            rpn_pkg::B_DIV: begin
                if (w_div_rsp.done) begin
                    w_we    = 1'b1;
                    w_waddr = r_sp[AW-1:0];
                    w_wdata = (r_kind == rpn_pkg::K_MOD) ? w_modres : w_divres;
                    n_sp    = w_sp_p1;
                    n_state = rpn_pkg::B_OUT;
                end
            end

            rpn_pkg::B_OUT: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    n_state    = rpn_pkg::B_IDLE;
                end
            end

            default: begin
                n_state = rpn_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rpn_pkg::B_IDLE;
            r_sp      <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
            if (w_load_out) begin
                r_o_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_b     <= n_b;
        r_empty <= n_empty;
        r_miss  <= n_miss;
        r_neg   <= n_neg;
        r_prod  <= n_prod;
        r_err   <= n_err;
        r_top   <= n_top;
        r_sec   <= n_sec;
        r_vld   <= n_vld;
        if (w_load_out) begin
            r_o_top <= r_top;
            r_o_sec <= r_sec;
            r_o_vld <= r_vld;
            r_o_err <= r_err;
        end
    end

    // stack storage
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    assign o_res.valid        = r_o_valid;
    assign o_res.top_value    = r_o_top;
    assign o_res.second_value = r_o_sec;
    assign o_res.value_valid  = r_o_vld;
    assign o_res.error_code   = r_o_err;

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= DEPTH_W)
        else $error("stack pointer beyond depth");

    a_out_keeps_sp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rpn_pkg::B_OUT) |=> (r_sp == $past(r_sp)))
        else $error("stack pointer moved while delivering a word");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rpn_pkg::B_OUT && w_out_free) |=> r_o_valid)
        else $error("result word not presented");

    a_idle_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rpn_pkg::B_IDLE && !i_cmd_valid) |=> (r_state == rpn_pkg::B_IDLE))
        else $error("back end left idle without a command");

endmodule

### tb/sv/tb_rpn_stack_calculator.sv
// tb_rpn_stack_calculator: token/result testbench for the reverse Polish Q16.16 calculator
// depends on rpn_pkg, the rpn_tok_if/rpn_res_if channels and rpn_stack_calculator
// a shadow stack predicts each result word; both channels idle at random

`timescale 1ns / 1ps

module tb_rpn_stack_calculator;

    localparam int STACK_DEPTH  = 128;
    localparam int RANDOM_ITEMS = 450;
    localparam int DRAIN_CYCLES = 80;
    localparam int ONE_INT      = 1 << rpn_pkg::FRAC;
    localparam longint ONE_Q    = longint'(1) << rpn_pkg::FRAC;

    localparam logic [rpn_pkg::W_OP-1:0] OP_UNUSED_LO = 4'd10;
    localparam logic [rpn_pkg::W_OP-1:0] OP_CODE_MAX  = 4'd15;
    localparam logic [rpn_pkg::W_OP-1:0] ARITH_OPS [5] = '{
        rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL, rpn_pkg::OP_DIV, rpn_pkg::OP_MOD
    };

    typedef struct packed {
        logic signed [rpn_pkg::W_VAL-1:0] top;
        logic signed [rpn_pkg::W_VAL-1:0] second;
        logic                             vld;
        rpn_pkg::t_err                    err;
    } t_result_word;

    class calc_tracker;
        logic signed [rpn_pkg::W_VAL-1:0] stack_mem [STACK_DEPTH];
        int unsigned                      depth;
        t_result_word                     owed_words [$];
        int                               errors;
        int                               words_seen;

        function new();
            depth      = 0;
            errors     = 0;
            words_seen = 0;
        endfunction

        function logic signed [rpn_pkg::W_VAL-1:0] take_value(inout bit empty);
            if (depth > 0) begin
                depth--;
                return stack_mem[depth];
            end
            empty = 1'b1;
            return '0;
        endfunction

        function bit give_value(logic signed [rpn_pkg::W_VAL-1:0] v);
            if (depth < STACK_DEPTH) begin
                stack_mem[depth] = v;
                depth++;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function logic signed [rpn_pkg::W_VAL-1:0] saturate(longint v);
            if (v > 64'sd2147483647)
                return rpn_pkg::VAL_MAX;
            if (v < -64'sd2147483648)
                return rpn_pkg::VAL_MIN;
            return v[rpn_pkg::W_VAL-1:0];
        endfunction

        function t_result_word evaluate_token(logic [rpn_pkg::W_OP-1:0] op,
                                              logic signed [rpn_pkg::W_VAL-1:0] val);
            t_result_word                     w;
            bit                               empty;
            logic signed [rpn_pkg::W_VAL-1:0] a;
            logic signed [rpn_pkg::W_VAL-1:0] b;
            logic signed [rpn_pkg::W_VAL-1:0] t;
            int                               ai;
            int                               bi;
            longint                           r;
            w.top    = '0;
            w.second = '0;
            w.vld    = 1'b0;
            w.err    = rpn_pkg::ERR_OK;
            empty    = 1'b0;
            case (op)
                rpn_pkg::OP_PUSH: begin
                    if (!give_value(val))
                        w.err = rpn_pkg::ERR_FULL;
                end
                rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL: begin
                    b = take_value(empty);
                    a = take_value(empty);
                    if (op == rpn_pkg::OP_ADD)
                        r = longint'(a) + longint'(b);
                    else if (op == rpn_pkg::OP_SUB)
                        r = longint'(a) - longint'(b);
                    else
                        r = (longint'(a) * longint'(b)) / ONE_Q;
                    void'(give_value(saturate(r)));
                    if (empty)
                        w.err = rpn_pkg::ERR_EMPTY;
                end
                rpn_pkg::OP_DIV: begin
                    b = take_value(empty);
                    if (b == 0) begin
                        if (empty)
                            w.err = rpn_pkg::ERR_EMPTY;
                        else
                            w.err = rpn_pkg::ERR_ZERO_DIV;
                    end else begin
                        a = take_value(empty);
                        r = (longint'(a) * ONE_Q) / longint'(b);
                        void'(give_value(saturate(r)));
                        if (empty)
                            w.err = rpn_pkg::ERR_EMPTY;
                    end
                end
                rpn_pkg::OP_MOD: begin
                    b  = take_value(empty);
                    bi = int'(b) / ONE_INT;
                    if (bi == 0) begin
                        if (empty)
                            w.err = rpn_pkg::ERR_EMPTY;
                        else
                            w.err = rpn_pkg::ERR_ZERO_DIV;
                    end else begin
                        a  = take_value(empty);
                        ai = int'(a) / ONE_INT;
                        r  = longint'(ai % bi) * ONE_Q;
                        void'(give_value(saturate(r)));
                        if (empty)
                            w.err = rpn_pkg::ERR_EMPTY;
                    end
                end
                rpn_pkg::OP_CLEAR: depth = 0;
                rpn_pkg::OP_PEEK: begin
                    if (depth < 2) begin
                        w.err = rpn_pkg::ERR_SHORT;
                    end else begin
                        w.top    = stack_mem[depth-1];
                        w.second = stack_mem[depth-2];
                        w.vld    = 1'b1;
                    end
                end
                rpn_pkg::OP_SWAP: begin
                    if (depth < 2) begin
                        w.err = rpn_pkg::ERR_SHORT;
                    end else begin
                        t                  = stack_mem[depth-1];
                        stack_mem[depth-1] = stack_mem[depth-2];
                        stack_mem[depth-2] = t;
                    end
                end
                rpn_pkg::OP_POP: begin
                    w.top = take_value(empty);
                    if (empty)
                        w.err = rpn_pkg::ERR_EMPTY;
                    else
                        w.vld = 1'b1;
                end
                default: ;
            endcase
            return w;
        endfunction

        function void note_token(logic [rpn_pkg::W_OP-1:0] op,
                                 logic signed [rpn_pkg::W_VAL-1:0] val);
            owed_words.push_back(evaluate_token(op, val));
        endfunction

        task report_mismatch(string msg);
            $display("%0t mismatch word %0d: %s", $realtime, words_seen, msg);
            errors++;
        endtask

        task check_result(t_result_word got);
            t_result_word want;
            words_seen++;
            if (owed_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word top=%h err=%0d",
                                          got.top, got.err));
                return;
            end
            want = owed_words.pop_front();
            if (got.top !== want.top)
                report_mismatch($sformatf("top_value %h, want %h", got.top, want.top));
            if (got.second !== want.second)
                report_mismatch($sformatf("second_value %h, want %h",
                                          got.second, want.second));
            if (got.vld !== want.vld)
                report_mismatch($sformatf("value_valid %b, want %b", got.vld, want.vld));
            if (got.err !== want.err)
                report_mismatch($sformatf("error_code %0d, want %0d", got.err, want.err));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    rpn_tok_if tok_if ();
    rpn_res_if res_if ();

    calc_tracker book = new();
    int tok_calm = 0;
    int res_calm = 0;
    int tokens_sent = 0;

    rpn_stack_calculator #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_tok   (tok_if),
        .o_res   (res_if)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // mostly short gaps, a few long ones, and now and then a run with none
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm = $urandom_range(8, 30);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [rpn_pkg::W_VAL-1:0] random_operand();
        logic signed [rpn_pkg::W_VAL-1:0] edges [7];
        edges = '{rpn_pkg::VAL_MAX, rpn_pkg::VAL_MIN, 32'sh0, -32'sh1, 32'sh1,
                  32'sh0001_0000, 32'shFFFF_0000};
        case ($urandom_range(0, 9))
            0: return edges[$urandom_range(0, 6)];
            1, 2, 3: return (int'($urandom_range(0, 40)) - 20) <<< rpn_pkg::FRAC;
            4, 5: return int'($urandom_range(0, 1 << 19)) - (1 << 18);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_token(input logic [rpn_pkg::W_OP-1:0] op,
                              input logic signed [rpn_pkg::W_VAL-1:0] val);
        int gap;
        gap = pick_gap(tok_calm);
        if (gap > 0) begin
            tok_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tok_if.valid         <= 1'b1;
        tok_if.operation     <= op;
        tok_if.operand_value <= val;
        @(posedge clk);
        while (!tok_if.ready)
            @(posedge clk);
        book.note_token(op, val);
        if (op <= rpn_pkg::OP_POP)
            tokens_sent++;
    endtask

    // result side
    initial begin
        int           gap;
        t_result_word got;
        res_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            gap = pick_gap(res_calm);
            if (gap > 0) begin
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            @(posedge clk);
            while (!res_if.valid)
                @(posedge clk);
            got.top    = res_if.top_value;
            got.second = res_if.second_value;
            got.vld    = res_if.value_valid;
            got.err    = rpn_pkg::t_err'(res_if.error_code);
            book.check_result(got);
        end
    end

    // token side
    initial begin
        logic [rpn_pkg::W_OP-1:0] op;
        int                       n;
        bit                       filled;
        filled = 1'b0;
        rst_n                <= 1'b0;
        tok_if.valid         <= 1'b0;
        tok_if.operation     <= rpn_pkg::OP_PUSH;
        tok_if.operand_value <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty and short stack cases
        send_token(rpn_pkg::OP_POP, 32'sh0);
        send_token(rpn_pkg::OP_ADD, 32'sh0);
        send_token(rpn_pkg::OP_PEEK, 32'sh0);
        send_token(rpn_pkg::OP_SWAP, -32'sh1);
        send_token(rpn_pkg::OP_CLEAR, 32'sh0);
        send_token(rpn_pkg::OP_DIV, 32'sh0);
        send_token(rpn_pkg::OP_MOD, 32'sh0);
        // saturation
        send_token(rpn_pkg::OP_PUSH, rpn_pkg::VAL_MAX);
        send_token(rpn_pkg::OP_PUSH, rpn_pkg::VAL_MAX);
        send_token(rpn_pkg::OP_ADD, 32'sh0);
        send_token(rpn_pkg::OP_PUSH, rpn_pkg::VAL_MIN);
        send_token(rpn_pkg::OP_MUL, 32'sh0);
        send_token(rpn_pkg::OP_PUSH, 32'sh1);
        send_token(rpn_pkg::OP_SUB, 32'sh0);
        // zero divisors, then a divisor of minus one LSB
        send_token(rpn_pkg::OP_PUSH, 32'sh0);
        send_token(rpn_pkg::OP_DIV, rpn_pkg::VAL_MAX);
        send_token(rpn_pkg::OP_PUSH, 32'sh0000_8000);
        send_token(rpn_pkg::OP_MOD, rpn_pkg::VAL_MIN);
        send_token(rpn_pkg::OP_PUSH, -32'sh1);
        send_token(rpn_pkg::OP_DIV, 32'sh0);
        // peek, swap, modulo, unused code, pop
        send_token(rpn_pkg::OP_PUSH, 32'sh0003_0000);
        send_token(rpn_pkg::OP_PEEK, 32'sh0);
        send_token(rpn_pkg::OP_SWAP, 32'sh0);
        send_token(rpn_pkg::OP_MOD, 32'sh0);
        send_token(OP_CODE_MAX, rpn_pkg::VAL_MAX);
        send_token(rpn_pkg::OP_POP, 32'sh0);

        tokens_sent = 0;
        while (tokens_sent < RANDOM_ITEMS) begin
            if (!filled && tokens_sent > 150) begin
                filled = 1'b1;
                while (book.depth < STACK_DEPTH)
                    send_token(rpn_pkg::OP_PUSH, random_operand());
                send_token(rpn_pkg::OP_PUSH, random_operand());
                send_token(rpn_pkg::OP_PUSH, random_operand());
                send_token(rpn_pkg::OP_PEEK, random_operand());
                send_token(rpn_pkg::OP_SWAP, random_operand());
                send_token(rpn_pkg::OP_MUL, random_operand());
                send_token(rpn_pkg::OP_PUSH, random_operand());
                send_token(rpn_pkg::OP_PUSH, random_operand());
                send_token(rpn_pkg::OP_POP, random_operand());
                send_token(rpn_pkg::OP_CLEAR, random_operand());
            end
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
                    n = $urandom_range(1, 3);
                    repeat (n) send_token(rpn_pkg::OP_PUSH, random_operand());
                    n = $urandom_range(1, 2);
                    repeat (n) send_token(ARITH_OPS[$urandom_range(0, 4)], random_operand());
                    if ($urandom_range(0, 3) == 0)
                        send_token($urandom_range(0, 1) ? rpn_pkg::OP_PEEK : rpn_pkg::OP_SWAP,
                                   random_operand());
                    if ($urandom_range(0, 4) != 0)
                        send_token(rpn_pkg::OP_POP, random_operand());
                end
                12, 13, 14, 15: begin
                    op = rpn_pkg::W_OP'($urandom_range(rpn_pkg::OP_PUSH, rpn_pkg::OP_POP));
                    send_token(op, random_operand());
                end
                16: send_token(rpn_pkg::OP_CLEAR, random_operand());
                17: begin
                    op = rpn_pkg::W_OP'($urandom_range(OP_UNUSED_LO, OP_CODE_MAX));
                    send_token(op, random_operand());
                end
                default: send_token(rpn_pkg::OP_POP, random_operand());
            endcase
            if (book.depth > 24)
                send_token(rpn_pkg::OP_CLEAR, random_operand());
        end
        tok_if.valid <= 1'b0;

        while (book.owed_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (book.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(12 * 600000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
